[rtl/bqc_pkg.sv]
// Shared types and constants for the biquad cascade filter core.
`default_nettype none

package bqc_pkg;

    // Fixed-point widths
    localparam int SAMPLE_W          = 16;
    localparam int COEF_W            = 32;
    localparam int PROD_W            = 48;
    localparam int DELAY_W           = 48;
    localparam int ACC_W             = 50;
    localparam int FRAC_SHIFT        = 15;
    localparam int COEF_INDEX_W      = 6;
    localparam int ACTIVE_W          = 4;
    localparam int COEFS_PER_SECTION = 5;

    // Register file decode (one 32-bit register per word)
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [0:0] REG_ACTIVE_SECTIONS = 1'b0;

    // Input command codes
    typedef enum logic [1:0] {
        CMD_SAMPLE = 2'd0,
        CMD_COEF   = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_NOP    = 2'd3
    } bqc_cmd_code_t;

    // Coefficient slot within a section, also the datapath step
    typedef enum logic [2:0] {
        STEP_B0 = 3'd0,
        STEP_B1 = 3'd1,
        STEP_B2 = 3'd2,
        STEP_A1 = 3'd3,
        STEP_A2 = 3'd4
    } bqc_step_t;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN0,
        ST_DRAIN1,
        ST_DONE
    } bqc_state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic      start;
        logic      coef_wr;
        logic      clear;
        logic      issue;
        bqc_step_t step;
        logic      out_load;
    } bqc_ctl_t;

    // Datapath to controller status
    typedef struct packed {
        logic out_busy;
    } bqc_stat_t;

endpackage

`default_nettype wire

[rtl/bqc_ram.sv]
// Generic single-port-write, registered-read RAM.
`default_nettype none

module bqc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 40,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[rtl/bqc_ctrl.sv]
// Sequencer for the biquad cascade: walks sections and coefficient steps.
`default_nettype none

module bqc_ctrl #(
    parameter int MAX_SECTIONS = 8,
    localparam int IW = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [1:0]                     cmd,
    input  wire logic [bqc_pkg::ACTIVE_W-1:0]   active_sections,
    input  wire bqc_pkg::bqc_stat_t             stat,
    output bqc_pkg::bqc_ctl_t                   ctl,
    output logic [IW-1:0]                       sec
);

    import bqc_pkg::*;

    localparam int CW = $clog2(MAX_SECTIONS + 1);

    bqc_state_t     state_reg, state_next;
    bqc_step_t      step_reg, step_next;
    logic [CW-1:0]  sec_reg, sec_next;
    logic [CW-1:0]  nsec_reg, nsec_next;
    logic [CW-1:0]  n_eff;
    logic [CW-1:0]  sec_inc;
    logic           accept;
    logic           last_issue;

    // Sections in use, clamped to what is built
    assign n_eff = (int'(active_sections) > MAX_SECTIONS) ? CW'(MAX_SECTIONS)
                                                          : CW'(active_sections);

    assign accept     = in_valid && (state_reg == ST_IDLE);
    assign sec_inc    = sec_reg + CW'(1);
    assign last_issue = (step_reg == STEP_A2) && (sec_inc == nsec_reg);

    // State and counter registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= STEP_B0;
            sec_reg   <= '0;
            nsec_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            sec_reg   <= sec_next;
            nsec_reg  <= nsec_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (cmd == CMD_SAMPLE))
                begin
                    state_next = (n_eff == '0) ? ST_DONE : ST_ISSUE;
                end
            end
            ST_ISSUE:
            begin
                if (last_issue)
                begin
                    state_next = ST_DRAIN0;
                end
            end
            ST_DRAIN0: state_next = ST_DRAIN1;
            ST_DRAIN1: state_next = ST_DONE;
            ST_DONE:
            begin
                if (!stat.out_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // Step and section counters
    always_comb
    begin
        step_next = step_reg;
        sec_next  = sec_reg;
        nsec_next = nsec_reg;
        if (state_reg == ST_IDLE)
        begin
            step_next = STEP_B0;
            sec_next  = '0;
            nsec_next = n_eff;
        end
        else if (state_reg == ST_ISSUE)
        begin
            case (step_reg)
                STEP_B0: step_next = STEP_B1;
                STEP_B1: step_next = STEP_B2;
                STEP_B2: step_next = STEP_A1;
                STEP_A1: step_next = STEP_A2;
                STEP_A2:
                begin
                    step_next = STEP_B0;
                    sec_next  = sec_inc;
                end
                default: step_next = STEP_B0;
            endcase
        end
    end

    // Outputs
    always_comb
    begin
        in_ready     = (state_reg == ST_IDLE);
        ctl.start    = accept && (cmd == CMD_SAMPLE);
        ctl.coef_wr  = accept && (cmd == CMD_COEF);
        ctl.clear    = accept && (cmd == CMD_CLEAR);
        ctl.issue    = (state_reg == ST_ISSUE);
        ctl.step     = step_reg;
        ctl.out_load = (state_reg == ST_DONE) && !stat.out_busy;
        sec          = IW'(sec_reg);
    end

endmodule

`default_nettype wire

[rtl/bqc_dp.sv]
// Datapath: coefficient store, shared multiplier, accumulators, delays, output register.
`default_nettype none

module bqc_dp #(
    parameter int MAX_SECTIONS = 8,
    localparam int IW = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire bqc_pkg::bqc_ctl_t                   ctl,
    input  wire logic [IW-1:0]                       sec,
    input  wire logic signed [bqc_pkg::SAMPLE_W-1:0] sample_in,
    input  wire logic                                block_last_in,
    input  wire logic [bqc_pkg::COEF_INDEX_W-1:0]    coef_index,
    input  wire logic signed [bqc_pkg::COEF_W-1:0]   coef_value,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic signed [bqc_pkg::SAMPLE_W-1:0]      sample_out,
    output logic                                     block_last_out,
    output logic                                     saturated,
    output bqc_pkg::bqc_stat_t                       stat
);

    import bqc_pkg::*;

    localparam int NCOEF = MAX_SECTIONS * COEFS_PER_SECTION;
    localparam int AW    = (NCOEF > 1) ? $clog2(NCOEF) : 1;
    localparam int RW    = PROD_W - FRAC_SHIFT;
    localparam int YW    = ACC_W - FRAC_SHIFT;
    localparam logic signed [PROD_W-1:0] PROD_HALF = PROD_W'(1) <<< (FRAC_SHIFT - 1);
    localparam logic signed [ACC_W-1:0]  ACC_HALF  = ACC_W'(1) <<< (FRAC_SHIFT - 1);

    // Coefficient store and its written-slot bits
    logic [NCOEF-1:0]          coef_vld_reg;
    logic                      coef_wr_ok;
    logic [AW-1:0]             coef_waddr;
    logic [AW-1:0]             rd_addr;
    logic [COEF_W-1:0]         ram_rdata;
    logic                      coef_ok_reg;

    // Pipeline control
    logic                      p1_valid_reg;
    bqc_step_t                 p1_step_reg;
    logic [IW-1:0]             p1_sec_reg;
    logic                      p2_valid_reg;
    bqc_step_t                 p2_step_reg;
    logic [IW-1:0]             p2_sec_reg;

    // Arithmetic
    logic signed [SAMPLE_W-1:0] x_reg;
    logic signed [SAMPLE_W-1:0] y_reg;
    logic signed [SAMPLE_W-1:0] y_next;
    logic signed [COEF_W-1:0]   coef_s;
    logic signed [SAMPLE_W-1:0] op_s;
    logic signed [PROD_W-1:0]   prod_next;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [PROD_W-1:0]   prod_rnd;
    logic signed [RW-1:0]       r_s;
    logic signed [ACC_W-1:0]    r_ext;
    logic signed [ACC_W-1:0]    da_ext;
    logic signed [ACC_W-1:0]    db_ext;
    logic signed [ACC_W-1:0]    acc0;
    logic signed [ACC_W-1:0]    y_rnd;
    logic signed [YW-1:0]       y_wide;
    logic                       y_clip;
    logic signed [ACC_W-1:0]    acca_reg;
    logic signed [ACC_W-1:0]    accb_reg;
    logic signed [ACC_W-1:0]    upd_sum;
    logic signed [DELAY_W-1:0]  upd_sat;
    logic                       upd_clip;
    logic                       sat_reg;
    logic                       last_reg;

    // Delay line state
    logic signed [DELAY_W-1:0]  da_reg [MAX_SECTIONS];
    logic signed [DELAY_W-1:0]  db_reg [MAX_SECTIONS];

    // Output register
    logic                       out_valid_reg;
    logic signed [SAMPLE_W-1:0] sample_out_reg;
    logic                       last_out_reg;
    logic                       sat_out_reg;

    // Coefficient write decode; slots past the store are dropped
    assign coef_wr_ok = ctl.coef_wr && (int'(coef_index) < NCOEF);
    assign coef_waddr = AW'(coef_index);

    // Read address: five slots per section
    assign rd_addr = (AW'(sec) << 2) + AW'(sec) + AW'(ctl.step);

    bqc_ram #(
        .WIDTH (COEF_W),
        .DEPTH (NCOEF)
    ) u_coef_ram (
        .clk   (clk),
        .we    (coef_wr_ok),
        .waddr (coef_waddr),
        .wdata (coef_value),
        .re    (ctl.issue),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    // Written-slot bits; an unwritten slot reads as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_vld_reg <= '0;
        end
        else if (coef_wr_ok)
        begin
            coef_vld_reg[coef_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.issue)
        begin
            coef_ok_reg <= coef_vld_reg[rd_addr];
        end
    end

    // Pipeline control: read, multiply, accumulate
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
        end
        else
        begin
            p1_valid_reg <= ctl.issue;
            p2_valid_reg <= p1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        p1_step_reg <= ctl.step;
        p1_sec_reg  <= sec;
        p2_step_reg <= p1_step_reg;
        p2_sec_reg  <= p1_sec_reg;
    end

    // Multiply stage: feed-forward taps use x, feedback taps use y
    assign coef_s    = coef_ok_reg ? signed'(ram_rdata) : '0;
    assign op_s      = ((p1_step_reg == STEP_A1) || (p1_step_reg == STEP_A2)) ? y_reg : x_reg;
    assign prod_next = op_s * coef_s;

    always_ff @(posedge clk)
    begin
        if (p1_valid_reg)
        begin
            prod_reg <= prod_next;
        end
    end

    // Section input: sample on start, previous section output after its last tap
    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            x_reg    <= sample_in;
            last_reg <= block_last_in;
        end
        else if (p1_valid_reg && (p1_step_reg == STEP_A2))
        begin
            x_reg <= y_reg;
        end
    end

    // Product rounding to 30 fraction bits
    assign prod_rnd = prod_reg + PROD_HALF;
    assign r_s      = prod_rnd[PROD_W-1:FRAC_SHIFT];
    assign r_ext    = {{(ACC_W - RW){r_s[RW-1]}}, r_s};
    assign da_ext   = {{(ACC_W - DELAY_W){da_reg[p2_sec_reg][DELAY_W-1]}}, da_reg[p2_sec_reg]};
    assign db_ext   = {{(ACC_W - DELAY_W){db_reg[p2_sec_reg][DELAY_W-1]}}, db_reg[p2_sec_reg]};

    // Section output: round and clip to Q1.15
    assign acc0   = r_ext + da_ext;
    assign y_rnd  = acc0 + ACC_HALF;
    assign y_wide = y_rnd[ACC_W-1:FRAC_SHIFT];
    assign y_clip = (y_wide[YW-1:SAMPLE_W-1] != {(YW - SAMPLE_W + 1){y_wide[SAMPLE_W-1]}});

    always_comb
    begin
        if (!y_clip)
        begin
            y_next = y_wide[SAMPLE_W-1:0];
        end
        else if (y_wide[YW-1])
        begin
            y_next = {1'b1, {(SAMPLE_W - 1){1'b0}}};
        end
        else
        begin
            y_next = {1'b0, {(SAMPLE_W - 1){1'b1}}};
        end
    end

    // Delay update: subtract feedback term, clip to 48 bits
    assign upd_sum  = ((p2_step_reg == STEP_A1) ? acca_reg : accb_reg) - r_ext;
    assign upd_clip = (upd_sum[ACC_W-1:DELAY_W-1] != {(ACC_W - DELAY_W + 1){upd_sum[DELAY_W-1]}});

    always_comb
    begin
        if (!upd_clip)
        begin
            upd_sat = upd_sum[DELAY_W-1:0];
        end
        else if (upd_sum[ACC_W-1])
        begin
            upd_sat = {1'b1, {(DELAY_W - 1){1'b0}}};
        end
        else
        begin
            upd_sat = {1'b0, {(DELAY_W - 1){1'b1}}};
        end
    end

    // Accumulate stage
    always_ff @(posedge clk)
    begin
        if (p2_valid_reg)
        begin
            case (p2_step_reg)
                STEP_B0: y_reg    <= y_next;
                STEP_B1: acca_reg <= r_ext + db_ext;
                STEP_B2: accb_reg <= r_ext;
                default: ;
            endcase
        end
    end

    // Clip flag for the current sample
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sat_reg <= 1'b0;
        end
        else if (ctl.start)
        begin
            sat_reg <= 1'b0;
        end
        else if (p2_valid_reg)
        begin
            case (p2_step_reg)
                STEP_B0: sat_reg <= sat_reg | y_clip;
                STEP_A1: sat_reg <= sat_reg | upd_clip;
                STEP_A2: sat_reg <= sat_reg | upd_clip;
                default: ;
            endcase
        end
    end

    // Delay registers: cleared on reset and by the clear command
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_SECTIONS; i++)
            begin
                da_reg[i] <= '0;
                db_reg[i] <= '0;
            end
        end
        else if (ctl.clear)
        begin
            for (int i = 0; i < MAX_SECTIONS; i++)
            begin
                da_reg[i] <= '0;
                db_reg[i] <= '0;
            end
        end
        else if (p2_valid_reg && (p2_step_reg == STEP_A1))
        begin
            da_reg[p2_sec_reg] <= upd_sat;
        end
        else if (p2_valid_reg && (p2_step_reg == STEP_A2))
        begin
            db_reg[p2_sec_reg] <= upd_sat;
        end
    end

    // Output register: holds one result while the receiver stalls
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctl.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.out_load)
        begin
            sample_out_reg <= x_reg;
            last_out_reg   <= last_reg;
            sat_out_reg    <= sat_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign sample_out     = sample_out_reg;
    assign block_last_out = last_out_reg;
    assign saturated      = sat_out_reg;
    assign stat.out_busy  = out_valid_reg && !out_ready;

endmodule

`default_nettype wire

[rtl/biquad_cascade_filter_core.sv]
// Top level of the biquad cascade filter: register port, sequencer and datapath.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one command per transaction:
//   filter a sample, write one coefficient slot, or clear all section delays.
//   Only a filter command produces a transaction on the output channel
//   (out_valid/out_ready): the saturated Q1.15 result, the block-last marker
//   and a clip flag.
//   Coefficient writes and clears take effect when accepted and leave the block
//   ready in the next cycle. A sample's processing time grows with N, the active
//   section count: the single shared 16x32 multiplier serves the five
//   coefficients of each section one per cycle.
//   The output register holds a finished result while the receiver stalls; the
//   next command is accepted meanwhile, and a following sample waits in its
//   last cycle until the output register is free.
//   Reset clears the coefficient store (through per-slot written bits), all
//   delays, and sets active_sections to 1. active_sections sits at APB byte
//   address 0; write it only while the block is idle (the block does not check).
`default_nettype none

module biquad_cascade_filter_core #(
    parameter int MAX_SECTIONS = 8
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,

    // Configuration port
    input  wire logic                                  psel,
    input  wire logic                                  penable,
    input  wire logic                                  pwrite,
    input  wire logic [bqc_pkg::APB_ADDR_W-1:0]        paddr,
    input  wire logic [bqc_pkg::APB_DATA_W-1:0]        pwdata,
    output logic      [bqc_pkg::APB_DATA_W-1:0]        prdata,
    output logic                                       pready,

    // Input channel
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire logic [1:0]                            cmd,
    input  wire logic signed [bqc_pkg::SAMPLE_W-1:0]   sample_in,
    input  wire logic                                  block_last_in,
    input  wire logic [bqc_pkg::COEF_INDEX_W-1:0]      coef_index,
    input  wire logic signed [bqc_pkg::COEF_W-1:0]     coef_value,

    // Output channel
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic signed [bqc_pkg::SAMPLE_W-1:0]        sample_out,
    output logic                                       block_last_out,
    output logic                                       saturated
);

    import bqc_pkg::*;

    localparam int IW = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;

    logic [ACTIVE_W-1:0] active_sections_reg;
    logic                reg_sel;
    bqc_ctl_t            ctl;
    bqc_stat_t           stat;
    logic [IW-1:0]       sec;

    // Register decode: one word per register
    assign reg_sel = (paddr[2:2] == REG_ACTIVE_SECTIONS);
    assign pready  = 1'b1;
    assign prdata  = reg_sel ? {{(APB_DATA_W - ACTIVE_W){1'b0}}, active_sections_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_sections_reg <= ACTIVE_W'(1);
        end
        else if (psel && penable && pwrite && pready && reg_sel)
        begin
            active_sections_reg <= pwdata[ACTIVE_W-1:0];
        end
    end

    bqc_ctrl #(
        .MAX_SECTIONS (MAX_SECTIONS)
    ) u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .cmd             (cmd),
        .active_sections (active_sections_reg),
        .stat            (stat),
        .ctl             (ctl),
        .sec             (sec)
    );

    bqc_dp #(
        .MAX_SECTIONS (MAX_SECTIONS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctl            (ctl),
        .sec            (sec),
        .sample_in      (sample_in),
        .block_last_in  (block_last_in),
        .coef_index     (coef_index),
        .coef_value     (coef_value),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .sample_out     (sample_out),
        .block_last_out (block_last_out),
        .saturated      (saturated),
        .stat           (stat)
    );

endmodule

`default_nettype wire
